// File: hdl/two_nearest_ratio_test_matcher_core_defines.svh
// Assertion macros shared by the matcher modules.
`ifndef TWO_NEAREST_RATIO_TEST_MATCHER_CORE_DEFINES_SVH
`define TWO_NEAREST_RATIO_TEST_MATCHER_CORE_DEFINES_SVH

// Check on every clock edge outside reset.
`define TNRM_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);

// Check on every clock edge, reset included.
`define TNRM_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: hdl/tnrm_pkg.sv
package tnrm_pkg;

	localparam int BYTE_W     = 8;
	localparam int WORD_BYTES = 8;
	localparam int WORD_W     = BYTE_W * WORD_BYTES;

	localparam int SUM_W   = 23;
	localparam int DIST_W  = 27;
	localparam int RATIO_W = 8;
	localparam int PROD_W  = RATIO_W + DIST_W;

	localparam logic [DIST_W-1:0] FAR_DIST = DIST_W'(100000000);
	localparam logic [SUM_W-1:0]  SUM_MAX  = {SUM_W{1'b1}};

	localparam logic [RATIO_W-1:0] NUM_RESET = RATIO_W'(7 * 7);
	localparam logic [RATIO_W-1:0] DEN_RESET = RATIO_W'(10 * 10);
	localparam logic [SUM_W-1:0]   MAX_RESET = SUM_W'(12800);

	localparam int LANES_DEF        = 8;
	localparam int POINT_BITS_DEF   = 20;
	localparam int FEATURE_BITS_DEF = 16;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = SUM_W;

	localparam logic FUNC_CHUNK = 1'b0;
	localparam logic FUNC_END   = 1'b1;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_RATIO_NUM = 2'd0,
		CFG_RATIO_DEN = 2'd1,
		CFG_MAX_BEST  = 2'd2
	} cfg_idx_t;

	typedef struct packed {
		logic [RATIO_W-1:0] num;
		logic [RATIO_W-1:0] den;
		logic [SUM_W-1:0]   max_best;
	} cfg_regs_t;

	// Tracker contents taken at an end-of-feature request.
	typedef struct packed {
		logic              valid;
		logic              best_valid;
		logic [DIST_W-1:0] best_dist;
		logic [DIST_W-1:0] second_dist;
	} snap_t;

endpackage

// File: hdl/tnrm_ifs.sv
interface tnrm_item_if #(
	parameter int POINT_BITS   = tnrm_pkg::POINT_BITS_DEF,
	parameter int FEATURE_BITS = tnrm_pkg::FEATURE_BITS_DEF
);
	logic                        valid;
	logic                        ready;
	logic                        func;
	logic [tnrm_pkg::WORD_W-1:0] query_bytes;
	logic [tnrm_pkg::WORD_W-1:0] candidate_bytes;
	logic                        last_chunk;
	logic [POINT_BITS-1:0]       candidate_point;
	logic [FEATURE_BITS-1:0]     feature_id;

	modport source (output valid, func, query_bytes, candidate_bytes, last_chunk,
		candidate_point, feature_id, input ready);
	modport sink (input valid, func, query_bytes, candidate_bytes, last_chunk,
		candidate_point, feature_id, output ready);
endinterface

interface tnrm_result_if #(
	parameter int POINT_BITS   = tnrm_pkg::POINT_BITS_DEF,
	parameter int FEATURE_BITS = tnrm_pkg::FEATURE_BITS_DEF
);
	logic                       valid;
	logic                       ready;
	logic                       match_found;
	logic [POINT_BITS-1:0]      matched_point;
	logic [tnrm_pkg::SUM_W-1:0] best_distance_out;
	logic [FEATURE_BITS-1:0]    feature_out;

	modport source (output valid, match_found, matched_point, best_distance_out,
		feature_out, input ready);
	modport sink (input valid, match_found, matched_point, best_distance_out,
		feature_out, output ready);
endinterface

interface tnrm_cfg_if;
	logic                            valid;
	logic                            ready;
	logic [tnrm_pkg::CFG_IDX_W-1:0]  index;
	logic [tnrm_pkg::CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// File: hdl/tnrm_sqdiff.sv
module tnrm_sqdiff #(
	parameter int LANES = tnrm_pkg::LANES_DEF
) (
	input  logic [tnrm_pkg::WORD_W-1:0]                   query_bytes,
	input  logic [tnrm_pkg::WORD_W-1:0]                   candidate_bytes,
	output logic [2*tnrm_pkg::BYTE_W+$clog2(LANES)-1:0]   chunk_sum
);
	localparam int SQ_W    = 2 * tnrm_pkg::BYTE_W;
	localparam int CHUNK_W = SQ_W + $clog2(LANES);

	logic [tnrm_pkg::BYTE_W-1:0] diff [LANES];
	logic [SQ_W-1:0]             sq   [LANES];

	// Absolute difference and square per lane, then sum the lanes.
	always_comb begin
		logic [tnrm_pkg::BYTE_W-1:0] a;
		logic [tnrm_pkg::BYTE_W-1:0] b;
		logic [CHUNK_W-1:0]          acc;
		acc = '0;
		for (int i = 0; i < LANES; i++) begin
			a = query_bytes[i*tnrm_pkg::BYTE_W +: tnrm_pkg::BYTE_W];
			b = candidate_bytes[i*tnrm_pkg::BYTE_W +: tnrm_pkg::BYTE_W];
			diff[i] = (a > b) ? (a - b) : (b - a);
			sq[i] = SQ_W'(diff[i]) * SQ_W'(diff[i]);
			acc = acc + CHUNK_W'(sq[i]);
		end
		chunk_sum = acc;
	end
endmodule

// File: hdl/tnrm_tracker.sv
`include "two_nearest_ratio_test_matcher_core_defines.svh"

module tnrm_tracker #(
	parameter int LANES        = tnrm_pkg::LANES_DEF,
	parameter int POINT_BITS   = tnrm_pkg::POINT_BITS_DEF,
	parameter int FEATURE_BITS = tnrm_pkg::FEATURE_BITS_DEF
) (
	input  logic                                        clk,
	input  logic                                        arst_n,
	input  logic                                        advance,
	input  logic                                        valid_s1,
	input  logic                                        func_s1,
	input  logic [2*tnrm_pkg::BYTE_W+$clog2(LANES)-1:0] chunk_sum_s1,
	input  logic                                        last_s1,
	input  logic [POINT_BITS-1:0]                       point_s1,
	input  logic [FEATURE_BITS-1:0]                     feature_s1,
	output tnrm_pkg::snap_t                             snap_s3,
	output logic [POINT_BITS-1:0]                       best_point_s3,
	output logic [FEATURE_BITS-1:0]                     feature_s3
);
	localparam int CHUNK_W = 2 * tnrm_pkg::BYTE_W + $clog2(LANES);

	logic                          valid_s2;
	logic                          func_s2;
	logic [CHUNK_W-1:0]            chunk_sum_s2;
	logic                          last_s2;
	logic [POINT_BITS-1:0]         point_s2;
	logic [FEATURE_BITS-1:0]       feature_s2;

	logic [tnrm_pkg::SUM_W-1:0]    partial_q;
	logic [tnrm_pkg::DIST_W-1:0]   best_dist_q;
	logic [tnrm_pkg::DIST_W-1:0]   second_dist_q;
	logic [POINT_BITS-1:0]         best_point_q;
	logic                          best_valid_q;
	logic                          second_valid_q;

	logic [tnrm_pkg::SUM_W:0]      sum_wide;
	logic [tnrm_pkg::SUM_W-1:0]    sum_sat;
	logic [tnrm_pkg::DIST_W-1:0]   cand_dist;
	logic                          below_second;
	logic                          below_best;
	logic                          do_chunk;
	logic                          do_end;

	// Accumulate with saturation, then rank against the two trackers.
	assign sum_wide     = {1'b0, partial_q} + (tnrm_pkg::SUM_W + 1)'(chunk_sum_s2);
	assign sum_sat      = sum_wide[tnrm_pkg::SUM_W] ? tnrm_pkg::SUM_MAX
		: sum_wide[tnrm_pkg::SUM_W-1:0];
	assign cand_dist    = tnrm_pkg::DIST_W'(sum_sat);
	assign below_second = cand_dist < second_dist_q;
	assign below_best   = cand_dist < best_dist_q;
	assign do_chunk     = advance && valid_s2 && (func_s2 == tnrm_pkg::FUNC_CHUNK);
	assign do_end       = advance && valid_s2 && (func_s2 == tnrm_pkg::FUNC_END);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			func_s2      <= func_s1;
			chunk_sum_s2 <= chunk_sum_s1;
			last_s2      <= last_s1;
			point_s2     <= point_s1;
			feature_s2   <= feature_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			partial_q      <= '0;
			best_dist_q    <= tnrm_pkg::FAR_DIST;
			second_dist_q  <= tnrm_pkg::FAR_DIST;
			best_point_q   <= '0;
			best_valid_q   <= 1'b0;
			second_valid_q <= 1'b0;
		end else if (do_end) begin
			partial_q      <= '0;
			best_dist_q    <= tnrm_pkg::FAR_DIST;
			second_dist_q  <= tnrm_pkg::FAR_DIST;
			best_point_q   <= '0;
			best_valid_q   <= 1'b0;
			second_valid_q <= 1'b0;
		end else if (do_chunk) begin
			if (!last_s2) begin
				partial_q <= sum_sat;
			end else begin
				partial_q <= '0;
				if (below_second && below_best) begin
					// New best: old best drops to second.
					best_dist_q    <= cand_dist;
					best_point_q   <= point_s2;
					best_valid_q   <= 1'b1;
					second_dist_q  <= best_dist_q;
					second_valid_q <= best_valid_q;
				end else if (below_second) begin
					second_dist_q  <= cand_dist;
					second_valid_q <= 1'b1;
				end
			end
		end
	end

	// Snapshot for the evaluation stage; hold while the output is blocked.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			snap_s3 <= '0;
		end else begin
			if (advance) begin
				snap_s3.valid <= do_end;
			end
			if (do_end) begin
				snap_s3.best_valid  <= best_valid_q;
				snap_s3.best_dist   <= best_dist_q;
				snap_s3.second_dist <= second_dist_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_end) begin
			best_point_s3 <= best_point_q;
			feature_s3    <= feature_s2;
		end
	end

	`TNRM_ASSERT_ALWAYS(a_best_not_above_second, best_dist_q <= second_dist_q,
		"best distance above second distance")
	`TNRM_ASSERT(a_second_implies_best, second_valid_q |-> best_valid_q,
		"second tracker valid without a best")
	`TNRM_ASSERT(a_best_in_range,
		best_valid_q |-> (best_dist_q <= tnrm_pkg::DIST_W'(tnrm_pkg::SUM_MAX)),
		"valid best distance beyond saturation limit")
endmodule

// File: hdl/tnrm_eval.sv
module tnrm_eval #(
	parameter int POINT_BITS   = tnrm_pkg::POINT_BITS_DEF,
	parameter int FEATURE_BITS = tnrm_pkg::FEATURE_BITS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       load,
	input  logic                       take,
	input  tnrm_pkg::cfg_regs_t        cfg_regs,
	input  tnrm_pkg::snap_t            snap_s3,
	input  logic [POINT_BITS-1:0]      best_point_s3,
	input  logic [FEATURE_BITS-1:0]    feature_s3,
	output logic                       valid_q,
	output logic                       match_q,
	output logic [POINT_BITS-1:0]      point_q,
	output logic [tnrm_pkg::SUM_W-1:0] dist_q,
	output logic [FEATURE_BITS-1:0]    feature_q
);
	logic [tnrm_pkg::PROD_W-1:0] lhs;
	logic [tnrm_pkg::PROD_W-1:0] rhs;
	logic                        ratio_ok;
	logic                        abs_ok;

	// Ratio test by cross multiplication, plus the absolute limit.
	assign lhs      = tnrm_pkg::PROD_W'(cfg_regs.den) * tnrm_pkg::PROD_W'(snap_s3.best_dist);
	assign rhs      = tnrm_pkg::PROD_W'(cfg_regs.num) * tnrm_pkg::PROD_W'(snap_s3.second_dist);
	assign ratio_ok = lhs < rhs;
	assign abs_ok   = snap_s3.best_dist <= tnrm_pkg::DIST_W'(cfg_regs.max_best);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (take) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			match_q   <= snap_s3.best_valid && ratio_ok && abs_ok;
			point_q   <= snap_s3.best_valid ? best_point_s3 : '0;
			dist_q    <= snap_s3.best_valid ? snap_s3.best_dist[tnrm_pkg::SUM_W-1:0] : '0;
			feature_q <= feature_s3;
		end
	end
endmodule

// File: hdl/two_nearest_ratio_test_matcher_core.sv
// Channel   Role    Payload
// items     sink    func, query_bytes, candidate_bytes, last_chunk, candidate_point, feature_id
// results   source  match_found, matched_point, best_distance_out, feature_out
// cfg       sink    index, data (0 ratio numerator, 1 ratio denominator, 2 distance limit)
//
// One request is taken every cycle while the pipe is not stalled; each chunk carries LANES byte pairs.
// An end-of-feature request shows its result after it passes the input register,
// the lane sum register and the tracker snapshot, then the ratio multipliers
// into the output register.
// The feedback path is the saturating add and the two compares of the trackers.
// Reset clears the trackers and loads the register defaults; no clearing pass.
// Requests stall only when a result waits in the output register and a second
// end-of-feature request has reached the evaluation stage behind it.
`include "two_nearest_ratio_test_matcher_core_defines.svh"

module two_nearest_ratio_test_matcher_core #(
	parameter int LANES        = tnrm_pkg::LANES_DEF,
	parameter int POINT_BITS   = tnrm_pkg::POINT_BITS_DEF,
	parameter int FEATURE_BITS = tnrm_pkg::FEATURE_BITS_DEF
) (
	input logic        clk,
	input logic        arst_n,
	tnrm_item_if.sink  items,
	tnrm_result_if.source results,
	tnrm_cfg_if.sink   cfg
);
	localparam int CHUNK_W = 2 * tnrm_pkg::BYTE_W + $clog2(LANES);

	tnrm_pkg::cfg_regs_t         cfg_q;

	logic                        valid_s1;
	logic                        func_s1;
	logic [tnrm_pkg::WORD_W-1:0] query_s1;
	logic [tnrm_pkg::WORD_W-1:0] cand_s1;
	logic                        last_s1;
	logic [POINT_BITS-1:0]       point_s1;
	logic [FEATURE_BITS-1:0]     feature_s1;

	logic [CHUNK_W-1:0]          chunk_sum_s1;
	tnrm_pkg::snap_t             snap_s3;
	logic [POINT_BITS-1:0]       best_point_s3;
	logic [FEATURE_BITS-1:0]     feature_s3;
	logic                        advance;

	// Hold the whole pipe only when the evaluation stage cannot hand over.
	assign advance     = !(snap_s3.valid && results.valid && !results.ready);
	assign items.ready = advance;
	assign cfg.ready   = 1'b1;

	// Register writes; an index beyond the list is dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.num      <= tnrm_pkg::NUM_RESET;
			cfg_q.den      <= tnrm_pkg::DEN_RESET;
			cfg_q.max_best <= tnrm_pkg::MAX_RESET;
		end else if (cfg.valid) begin
			unique case (tnrm_pkg::cfg_idx_t'(cfg.index))
				tnrm_pkg::CFG_RATIO_NUM: cfg_q.num      <= cfg.data[tnrm_pkg::RATIO_W-1:0];
				tnrm_pkg::CFG_RATIO_DEN: cfg_q.den      <= cfg.data[tnrm_pkg::RATIO_W-1:0];
				tnrm_pkg::CFG_MAX_BEST:  cfg_q.max_best <= cfg.data[tnrm_pkg::SUM_W-1:0];
				default: ;
			endcase
		end
	end

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= items.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && items.valid) begin
			func_s1    <= items.func;
			query_s1   <= items.query_bytes;
			cand_s1    <= items.candidate_bytes;
			last_s1    <= items.last_chunk;
			point_s1   <= items.candidate_point;
			feature_s1 <= items.feature_id;
		end
	end

	tnrm_sqdiff #(
		.LANES (LANES)
	) u_sqdiff (
		.query_bytes     (query_s1),
		.candidate_bytes (cand_s1),
		.chunk_sum       (chunk_sum_s1)
	);

	tnrm_tracker #(
		.LANES        (LANES),
		.POINT_BITS   (POINT_BITS),
		.FEATURE_BITS (FEATURE_BITS)
	) u_tracker (
		.clk           (clk),
		.arst_n        (arst_n),
		.advance       (advance),
		.valid_s1      (valid_s1),
		.func_s1       (func_s1),
		.chunk_sum_s1  (chunk_sum_s1),
		.last_s1       (last_s1),
		.point_s1      (point_s1),
		.feature_s1    (feature_s1),
		.snap_s3       (snap_s3),
		.best_point_s3 (best_point_s3),
		.feature_s3    (feature_s3)
	);

	tnrm_eval #(
		.POINT_BITS   (POINT_BITS),
		.FEATURE_BITS (FEATURE_BITS)
	) u_eval (
		.clk           (clk),
		.arst_n        (arst_n),
		.load          (advance && snap_s3.valid),
		.take          (results.ready),
		.cfg_regs      (cfg_q),
		.snap_s3       (snap_s3),
		.best_point_s3 (best_point_s3),
		.feature_s3    (feature_s3),
		.valid_q       (results.valid),
		.match_q       (results.match_found),
		.point_q       (results.matched_point),
		.dist_q        (results.best_distance_out),
		.feature_q     (results.feature_out)
	);

	`TNRM_ASSERT(a_snap_held_on_stall,
		(snap_s3.valid && results.valid && !results.ready)
			|=> (snap_s3.valid && $stable(snap_s3.best_dist)),
		"evaluation stage lost its request during an output stall")
endmodule
